/* src/ckc_pkg.sv */
// Shared types, constants and register codes for the chord key capture block.
package ckc_pkg;

    localparam int NUM_KEYS = 32;
    localparam logic [31:0] KEY_SPAN = 32'((64'd1 << NUM_KEYS) - 64'd1);

    localparam logic [15:0] EXEC_WINDOW_RESET = 16'd50;
    localparam logic [15:0] CANCEL_TIMEOUT_RESET = 16'd2000;

    typedef enum logic [1:0] {
        CFG_CHORD_KEY_MASK    = 2'd0,
        CFG_MODIFIER_MASK     = 2'd1,
        CFG_EXEC_WINDOW_MS    = 2'd2,
        CFG_CANCEL_TIMEOUT_MS = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BUILD  = 2'd1,
        MODE_CANCEL = 2'd2
    } mode_t;

    typedef struct packed {
        logic [31:0] switches;
        logic [31:0] time_ms;
    } ckc_in_t;

    typedef struct packed {
        logic        suppress;
        logic        chord_fire;
        logic [31:0] chord_mask;
    } ckc_out_t;

    typedef struct packed {
        logic [31:0] chord_key_mask;
        logic [31:0] modifier_mask;
        logic [15:0] exec_window_ms;
        logic [15:0] cancel_timeout_ms;
    } ckc_cfg_t;

endpackage

/* src/ckc_cfg_regs.sv */
// Configuration register file for the chord key capture block.
module ckc_cfg_regs
    import ckc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output ckc_cfg_t    cfg
);

    ckc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chord_key_mask    <= '0;
            cfg_reg.modifier_mask     <= '0;
            cfg_reg.exec_window_ms    <= EXEC_WINDOW_RESET;
            cfg_reg.cancel_timeout_ms <= CANCEL_TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_CHORD_KEY_MASK: begin
                    cfg_reg.chord_key_mask <= cfg_wdata;
                end
                CFG_MODIFIER_MASK: begin
                    cfg_reg.modifier_mask <= cfg_wdata;
                end
                CFG_EXEC_WINDOW_MS: begin
                    cfg_reg.exec_window_ms <= cfg_wdata[15:0];
                end
                CFG_CANCEL_TIMEOUT_MS: begin
                    cfg_reg.cancel_timeout_ms <= cfg_wdata[15:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/ckc_core.sv */
// Chord capture state machine: state registers and per-sample next-state logic.
module ckc_core
    import ckc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  ckc_in_t  item,
    input  ckc_cfg_t cfg,
    output ckc_out_t result
);

    mode_t       mode_reg, mode_next;
    logic [31:0] captured_reg, captured_next;
    logic [31:0] prev_reg;
    logic [31:0] window_start_reg, window_start_next;
    logic        window_open_reg, window_open_next;
    logic [31:0] cancel_start_reg, cancel_start_next;

    logic [31:0] cur;
    logic [31:0] now;
    logic [31:0] cm;
    logic [31:0] pressed;
    logic [31:0] released;
    logic [31:0] chord_held;
    logic [31:0] chord_pressed;
    logic [31:0] chord_released;
    logic [31:0] cancelling;
    logic        fire;
    logic [31:0] fire_mask;

    assign cur            = item.switches & KEY_SPAN;
    assign now            = item.time_ms;
    assign cm             = cfg.chord_key_mask & KEY_SPAN;
    assign pressed        = cur & ~prev_reg;
    assign released       = prev_reg & ~cur;
    assign chord_held     = cur & cm;
    assign chord_pressed  = pressed & cm;
    assign chord_released = released & cm;
    assign cancelling     = pressed & ~cm & ~cfg.modifier_mask;

    always_comb begin
        mode_next         = mode_reg;
        captured_next     = captured_reg;
        window_start_next = window_start_reg;
        window_open_next  = window_open_reg;
        cancel_start_next = cancel_start_reg;
        fire              = 1'b0;
        fire_mask         = '0;

        case (mode_reg)
            MODE_BUILD: begin
                if (chord_pressed != '0) begin
                    captured_next = captured_reg | chord_held;
                end
                if (cancelling != '0) begin
                    mode_next         = MODE_CANCEL;
                    cancel_start_next = now;
                    window_open_next  = 1'b0;
                end
                if (chord_released != '0 && !window_open_next) begin
                    window_start_next = now;
                    window_open_next  = 1'b1;
                end
            end
            MODE_CANCEL: begin
                if (cancelling != '0) begin
                    cancel_start_next = now;
                end
                if (chord_released != '0 && !window_open_next) begin
                    window_start_next = now;
                    window_open_next  = 1'b1;
                end
                if ((now - cancel_start_next) >= {16'd0, cfg.cancel_timeout_ms}) begin
                    if (chord_held != '0) begin
                        mode_next        = MODE_BUILD;
                        captured_next    = chord_held;
                        window_open_next = 1'b0;
                    end else begin
                        mode_next         = MODE_IDLE;
                        captured_next     = '0;
                        window_open_next  = 1'b0;
                        cancel_start_next = '0;
                    end
                end
            end
            default: begin
                if (chord_pressed != '0) begin
                    mode_next        = MODE_BUILD;
                    captured_next    = chord_held;
                    window_open_next = 1'b0;
                end
            end
        endcase

        if (window_open_next && cur != '0
                && (now - window_start_next) >= {16'd0, cfg.exec_window_ms}) begin
            if (mode_next == MODE_BUILD) begin
                if (chord_held != '0) begin
                    captured_next    = chord_held;
                    window_open_next = 1'b0;
                end else begin
                    mode_next         = MODE_IDLE;
                    captured_next     = '0;
                    window_open_next  = 1'b0;
                    cancel_start_next = '0;
                end
            end else begin
                window_open_next = 1'b0;
            end
        end

        if (cur == '0) begin
            if (window_open_next && mode_next == MODE_BUILD) begin
                fire      = 1'b1;
                fire_mask = captured_next;
            end
            mode_next         = MODE_IDLE;
            captured_next     = '0;
            window_open_next  = 1'b0;
            cancel_start_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            captured_reg     <= '0;
            prev_reg         <= '0;
            window_start_reg <= '0;
            window_open_reg  <= 1'b0;
            cancel_start_reg <= '0;
        end else if (step) begin
            mode_reg         <= mode_next;
            captured_reg     <= captured_next;
            prev_reg         <= cur;
            window_start_reg <= window_start_next;
            window_open_reg  <= window_open_next;
            cancel_start_reg <= cancel_start_next;
        end
    end

    assign result.suppress   = (mode_next != MODE_IDLE);
    assign result.chord_fire = fire;
    assign result.chord_mask = fire_mask;

    // An idle machine holds no capture and no open window.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_IDLE |-> captured_reg == '0 && !window_open_reg)
        else $error("idle state carries a capture or an open window");

    // Building always has at least one captured chord key.
    a_build_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_BUILD |-> captured_reg != '0)
        else $error("building state with an empty capture");

    // A fired chord leaves the machine idle after the transaction.
    a_fire_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && fire |=> mode_reg == MODE_IDLE && prev_reg == '0)
        else $error("machine not idle after a chord fired");

    // A fired mask is never empty, and a fired result does not set suppress.
    a_fire_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        step && fire |-> fire_mask != '0 && !result.suppress)
        else $error("fired chord has an empty mask or suppress set");

endmodule

/* src/chord_key_capture_fsm.sv */
// Chord key capture block: input register, capture state machine and result register.
//
// The block takes one key-scan sample transaction per clock cycle and returns
// exactly one result transaction for each sample, in order. A sample is held in
// the input register, passes through the capture state machine, and its result
// is presented from the result register, where m_valid rises with it. Throughput
// is one transaction per cycle while m_ready is high; a stalled result holds both
// stages. Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata and should only be changed while no transactions are in flight.
module chord_key_capture_fsm
    import ckc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  ckc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ckc_out_t    m_data
);

    ckc_cfg_t cfg;
    logic     in_valid_reg;
    ckc_in_t  in_data_reg;
    logic     out_valid_reg;
    ckc_out_t out_data_reg;
    ckc_out_t result;
    logic     advance;

    ckc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ckc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* bench/tb_chord_key_capture_fsm.sv */
// Testbench for chord_key_capture_fsm: random and directed key-scan traffic against a predictor.
module tb_chord_key_capture_fsm;
    timeunit 1ns;
    timeprecision 1ps;

    import ckc_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    class chord_capture_scoreboard;
        logic [31:0] chord_keys;
        logic [31:0] mod_keys;
        logic [15:0] win_ms;
        logic [15:0] cancel_ms;
        mode_t       mode;
        logic [31:0] capture;
        logic [31:0] last_switches;
        logic [31:0] win_start;
        logic [31:0] cancel_start;
        logic        win_open;
        ckc_out_t    due_reports[$];
        int          errors;

        function new();
            chord_keys = '0;
            mod_keys = '0;
            win_ms = EXEC_WINDOW_RESET;
            cancel_ms = CANCEL_TIMEOUT_RESET;
            last_switches = '0;
            win_start = '0;
            errors = 0;
            drop_chord();
        endfunction

        function void drop_chord();
            mode = MODE_IDLE;
            capture = '0;
            win_open = 1'b0;
            cancel_start = '0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] value);
            case (idx)
                CFG_CHORD_KEY_MASK: chord_keys = value;
                CFG_MODIFIER_MASK: mod_keys = value;
                CFG_EXEC_WINDOW_MS: win_ms = value[15:0];
                CFG_CANCEL_TIMEOUT_MS: cancel_ms = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_scan(ckc_in_t scan);
            logic [31:0] cur;
            logic [31:0] now;
            logic [31:0] chords;
            logic [31:0] prev;
            logic [31:0] pressed;
            logic [31:0] released;
            logic [31:0] chord_held;
            logic [31:0] chord_pressed;
            logic [31:0] chord_released;
            logic [31:0] cancelling;
            ckc_out_t    want;
            cur = scan.switches & KEY_SPAN;
            now = scan.time_ms;
            chords = chord_keys & KEY_SPAN;
            prev = last_switches & KEY_SPAN;
            pressed = cur & ~prev;
            released = prev & ~cur;
            chord_held = cur & chords;
            chord_pressed = pressed & chords;
            chord_released = released & chords;
            cancelling = pressed & ~chords & ~mod_keys;
            want = '0;

            case (mode)
                MODE_BUILD: begin
                    if (chord_pressed != 0) capture |= chord_held;
                    if (cancelling != 0) begin
                        mode = MODE_CANCEL;
                        cancel_start = now;
                        win_open = 1'b0;
                    end
                    if (chord_released != 0 && !win_open) begin
                        win_start = now;
                        win_open = 1'b1;
                    end
                end
                MODE_CANCEL: begin
                    if (cancelling != 0) cancel_start = now;
                    if (chord_released != 0 && !win_open) begin
                        win_start = now;
                        win_open = 1'b1;
                    end
                    if (32'(now - cancel_start) >= {16'h0, cancel_ms}) begin
                        if (chord_held != 0) begin
                            mode = MODE_BUILD;
                            capture = chord_held;
                            win_open = 1'b0;
                        end else begin
                            drop_chord();
                        end
                    end
                end
                default: begin
                    if (chord_pressed != 0) begin
                        mode = MODE_BUILD;
                        capture = chord_held;
                        win_open = 1'b0;
                    end
                end
            endcase

            if (win_open && 32'(now - win_start) >= {16'h0, win_ms} && cur != 0) begin
                if (mode == MODE_BUILD) begin
                    if (chord_held != 0) begin
                        capture = chord_held;
                        win_open = 1'b0;
                    end else begin
                        drop_chord();
                    end
                end else begin
                    win_open = 1'b0;
                end
            end

            if (cur == 0) begin
                if (win_open && mode == MODE_BUILD) begin
                    want.chord_fire = 1'b1;
                    want.chord_mask = capture;
                end
                drop_chord();
            end

            last_switches = cur;
            want.suppress = (mode != MODE_IDLE);
            due_reports.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 100) begin
                $display("mismatch in %s: got %h, expected %h", what, got, want);
            end
        endtask

        task check_report(ckc_out_t got);
            ckc_out_t want;
            if (due_reports.size() == 0) begin
                report_mismatch("unexpected transaction",
                                {30'd0, got.suppress, got.chord_fire}, 32'd0);
            end else begin
                want = due_reports.pop_front();
                if (got.suppress !== want.suppress)
                    report_mismatch("suppress", 32'(got.suppress), 32'(want.suppress));
                if (got.chord_fire !== want.chord_fire)
                    report_mismatch("chord_fire", 32'(got.chord_fire), 32'(want.chord_fire));
                if (got.chord_mask !== want.chord_mask)
                    report_mismatch("chord_mask", got.chord_mask, want.chord_mask);
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ckc_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ckc_out_t    m_data;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_off = 1'b0;
    logic        pressure_req = 1'b0;
    int          scans_sent = 0;
    int          cycle_count = 0;
    logic [31:0] clock_ms = '0;
    chord_capture_scoreboard sb;

    chord_key_capture_fsm i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_report(m_data);
            m_ready <= !hold_off && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // The receiver stops for a long stretch while the sender keeps offering scans.
    initial begin
        wait (pressure_req);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    function automatic logic [31:0] some_of(logic [31:0] pool);
        int bit_idx;
        if (pool == 0) return '0;
        if ($urandom_range(0, 1) == 0) return pool & $urandom;
        do bit_idx = $urandom_range(0, 31); while (!pool[bit_idx]);
        return 32'd1 << bit_idx;
    endfunction

    function automatic logic [31:0] tick_time();
        logic [31:0] win;
        logic [31:0] hold;
        int          roll;
        win = {16'h0, sb.win_ms};
        hold = {16'h0, sb.cancel_ms};
        roll = $urandom_range(0, 19);
        if (roll < 12) clock_ms += $urandom_range(0, win / 4 + 2);
        else if (roll < 15) clock_ms += win + $urandom_range(0, 2) - 1;
        else if (roll < 17) clock_ms += hold + $urandom_range(0, 2) - 1;
        else if (roll == 17) clock_ms += $urandom;
        return clock_ms;
    endfunction

    task automatic send_scan(logic [31:0] keys, logic [31:0] stamp);
        ckc_in_t scan;
        scan.switches = keys;
        scan.time_ms = stamp;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= scan;
        do @(posedge aclk); while (!s_ready);
        sb.note_scan(scan);
        scans_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.due_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(logic [31:0] chords, logic [31:0] mods,
                                logic [15:0] win, logic [15:0] hold);
        logic [31:0] word;
        cfg_we <= 1'b1;
        cfg_index <= CFG_CHORD_KEY_MASK;
        cfg_wdata <= chords;
        sb.write_reg(CFG_CHORD_KEY_MASK, chords);
        @(posedge aclk);
        cfg_index <= CFG_MODIFIER_MASK;
        cfg_wdata <= mods;
        sb.write_reg(CFG_MODIFIER_MASK, mods);
        @(posedge aclk);
        word = {16'($urandom), win};
        cfg_index <= CFG_EXEC_WINDOW_MS;
        cfg_wdata <= word;
        sb.write_reg(CFG_EXEC_WINDOW_MS, word);
        @(posedge aclk);
        word = {16'($urandom), hold};
        cfg_index <= CFG_CANCEL_TIMEOUT_MS;
        cfg_wdata <= word;
        sb.write_reg(CFG_CANCEL_TIMEOUT_MS, word);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic chord_episode();
        logic [31:0] held;
        logic [31:0] others;
        others = ~(sb.chord_keys | sb.mod_keys);
        held = some_of(sb.chord_keys);
        if ($urandom_range(0, 3) == 0) held |= some_of(sb.mod_keys);
        send_scan(held, tick_time());
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: held |= some_of(sb.chord_keys);
                5, 6: held |= some_of(sb.mod_keys);
                7: held |= some_of(others);
                8, 9, 10: held &= ~some_of(held);
                11, 12: held &= ~some_of(held & sb.chord_keys);
                13: held = '0;
                14: ;
                default: held = $urandom;
            endcase
            send_scan(held, tick_time());
        end
        send_scan(32'h0, tick_time());
    endtask

    task automatic run_phase(logic [31:0] chords, logic [31:0] mods, logic [15:0] win,
                             logic [15:0] hold, int tx_pct, int rx_pct, int scans,
                             logic squeeze);
        int target;
        settle();
        program_regs(chords, mods, win, hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        pressure_req = squeeze;
        clock_ms = $urandom;
        target = scans_sent + scans;
        while (scans_sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) send_scan($urandom, tick_time());
            end else begin
                chord_episode();
            end
        end
    endtask

    // Chord keys are the low byte, modifiers the next byte, bit 16 is a stray key.
    task automatic directed_scans();
        send_scan(32'h0000_0000, 32'h0000_0000);
        send_scan(32'hFFFF_0000, 32'hFFFF_FFFF);
        send_scan(32'h0000_0000, 32'h0000_0000);
        send_scan(32'h0000_0003, 32'hFFFF_FFF0);
        send_scan(32'h0000_0001, 32'hFFFF_FFFA);
        send_scan(32'h0000_0000, 32'h0000_0004);
        send_scan(32'h0000_0007, 32'd100);
        send_scan(32'h0000_0003, 32'd101);
        send_scan(32'h0000_0003, 32'd151);
        send_scan(32'h0000_0000, 32'd152);
        send_scan(32'h0000_0005, 32'd200);
        send_scan(32'h0000_0001, 32'd201);
        send_scan(32'h0000_0000, 32'd400);
        send_scan(32'h0000_0001, 32'd1000);
        send_scan(32'h0001_0001, 32'd1001);
        send_scan(32'h0001_0001, 32'd1100);
        send_scan(32'h0001_0001, 32'd1201);
        send_scan(32'h0000_0000, 32'd1202);
        send_scan(32'h0000_0001, 32'd2000);
        send_scan(32'h0001_0000, 32'd2001);
        send_scan(32'h0001_0000, 32'd2201);
        send_scan(32'h0000_0000, 32'd2202);
        send_scan(32'h0000_0001, 32'd3000);
        send_scan(32'h0000_0101, 32'd3001);
        send_scan(32'h0000_0100, 32'd3002);
        send_scan(32'h0000_0000, 32'd3003);
        send_scan(32'h0000_0002, 32'd4000);
        send_scan(32'hFFFF_FFFF, 32'd4001);
        send_scan(32'h0000_0000, 32'd4002);
    endtask

    initial begin
        logic [31:0] picks;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        program_regs(32'h0000_00FF, 32'h0000_FF00, 16'd50, 16'd200);
        tx_idle_pct = 9;
        rx_idle_pct = 66;
        directed_scans();
        run_phase(32'h0000_00FF, 32'h0000_FF00, 16'd50, 16'd200, 9, 66, 150, 1'b0);
        picks = $urandom;
        run_phase(picks, $urandom & ~picks, 16'($urandom_range(0, 300)),
                  16'($urandom_range(0, 1000)), 9, 66, 170, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'h0, 16'd0, 16'hFFFF, 66, 9, 170, 1'b0);
        picks = $urandom;
        run_phase(picks, $urandom & ~picks, 16'hFFFF, 16'd0, 66, 9, 170, 1'b0);
        run_phase(32'h0F0F_0F0F, 32'hFFFF_FFFF, 16'($urandom_range(1, 100)),
                  16'($urandom_range(1, 500)), 0, 0, 170, 1'b1);
        run_phase(32'h0, 32'h0, EXEC_WINDOW_RESET, CANCEL_TIMEOUT_RESET, 0, 0, 80, 1'b0);
        settle();

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
